FILE: sv/hcpu_pkg.sv
package hcpu_pkg;

  // operation field ir[7:5]
  typedef enum logic [2:0] {
    INS_LD  = 3'd0,
    INS_AND = 3'd1,
    INS_OR  = 3'd2,
    INS_XOR = 3'd3,
    INS_ADD = 3'd4,
    INS_SUB = 3'd5,
    INS_ST  = 3'd6,
    INS_BR  = 3'd7
  } ins_e;

  // addressing and destination mode ir[4:2]
  typedef enum logic [2:0] {
    MODE_D_AC      = 3'd0,
    MODE_X_AC      = 3'd1,
    MODE_YD_AC     = 3'd2,
    MODE_YX_AC     = 3'd3,
    MODE_D_X       = 3'd4,
    MODE_D_Y       = 3'd5,
    MODE_D_OUT     = 3'd6,
    MODE_YXINC_OUT = 3'd7
  } mode_e;

  // bus source ir[1:0]
  typedef enum logic [1:0] {
    BUS_D   = 2'd0,
    BUS_RAM = 2'd1,
    BUS_AC  = 2'd2,
    BUS_IN  = 2'd3
  } bus_e;

  // register loaded by the alu
  typedef enum logic [2:0] {
    DEST_NONE = 3'd0,
    DEST_AC   = 3'd1,
    DEST_X    = 3'd2,
    DEST_Y    = 3'd3,
    DEST_OUT  = 3'd4
  } dest_e;

  // condition index for conditional branches
  localparam logic [1:0] COND_GT = 2'd0;
  localparam logic [1:0] COND_LT = 2'd1;
  localparam logic [1:0] COND_EQ = 2'd2;

  // architectural register file
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  ir;
    logic [7:0]  dr;
    logic [7:0]  ac;
    logic [7:0]  xr;
    logic [7:0]  yr;
    logic [7:0]  outr;
  } cpu_state_t;

  // outcome of one machine cycle
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  ac;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  outr;
    logic [7:0]  bus;
    logic [7:0]  alu;
    logic [15:0] addr;
    logic        store;
    logic        jump;
  } exec_res_t;

  // data address formed by the mode; a branch uses {0, d}
  function automatic logic [15:0] mode_addr(logic [7:0] ir, logic [7:0] dr,
                                            logic [7:0] xr, logic [7:0] yr);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = dr;
    hi = 8'h00;
    if (ins_e'(ir[7:5]) != INS_BR) begin
      case (mode_e'(ir[4:2]))
        MODE_X_AC: lo = xr;
        MODE_YD_AC: hi = yr;
        MODE_YX_AC, MODE_YXINC_OUT: begin
          lo = xr;
          hi = yr;
        end
        default: ;
      endcase
    end
    return {hi, lo};
  endfunction

endpackage

FILE: sv/hcpu_in_if.sv
interface hcpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] fetched_opcode;
  logic [7:0] fetched_operand;
  logic [7:0] in_port;
  logic [7:0] noise_byte;

  modport source (output valid, fetched_opcode, fetched_operand, in_port, noise_byte,
                  input ready);
  modport sink (input valid, fetched_opcode, fetched_operand, in_port, noise_byte,
                output ready);
endinterface

FILE: sv/hcpu_out_if.sv
interface hcpu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fetch_address;
  logic [7:0]  out_port;
  logic [7:0]  accumulator;
  logic [7:0]  x_value;
  logic [7:0]  y_value;
  logic [7:0]  bus_value;
  logic [7:0]  alu_value;
  logic [15:0] ram_address;
  logic        ram_written;
  logic        jump_op;

  modport source (output valid, fetch_address, out_port, accumulator, x_value, y_value,
                  bus_value, alu_value, ram_address, ram_written, jump_op,
                  input ready);
  modport sink (input valid, fetch_address, out_port, accumulator, x_value, y_value,
                bus_value, alu_value, ram_address, ram_written, jump_op,
                output ready);
endinterface

FILE: sv/hcpu_ram.sv
module hcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/hcpu_exec.sv
module hcpu_exec (
  input  hcpu_pkg::cpu_state_t state_i,
  input  logic [7:0]           ram_data_i,
  input  logic [7:0]           in_port_i,
  input  logic [7:0]           noise_i,
  output hcpu_pkg::exec_res_t  res_o
);

  hcpu_pkg::ins_e  ins;
  hcpu_pkg::mode_e mode;
  hcpu_pkg::bus_e  bsel;
  hcpu_pkg::dest_e dest;
  logic            store;
  logic            jump;
  logic            incx;
  logic [7:0]      bus;
  logic [7:0]      alu;
  logic [1:0]      cond;
  logic [15:0]     pc_inc;
  logic [15:0]     pc_nxt;

  assign ins   = hcpu_pkg::ins_e'(state_i.ir[7:5]);
  assign mode  = hcpu_pkg::mode_e'(state_i.ir[4:2]);
  assign bsel  = hcpu_pkg::bus_e'(state_i.ir[1:0]);
  assign store = (ins == hcpu_pkg::INS_ST);
  assign jump  = (ins == hcpu_pkg::INS_BR);
  assign incx  = !jump && (mode == hcpu_pkg::MODE_YXINC_OUT);

  // destination decode, a store never loads ac or out
  always_comb begin
    dest = hcpu_pkg::DEST_NONE;
    if (!jump) begin
      case (mode)
        hcpu_pkg::MODE_D_AC, hcpu_pkg::MODE_X_AC,
        hcpu_pkg::MODE_YD_AC, hcpu_pkg::MODE_YX_AC: dest = hcpu_pkg::DEST_AC;
        hcpu_pkg::MODE_D_X: dest = hcpu_pkg::DEST_X;
        hcpu_pkg::MODE_D_Y: dest = hcpu_pkg::DEST_Y;
        default: dest = hcpu_pkg::DEST_OUT;
      endcase
      if (store && (dest == hcpu_pkg::DEST_AC || dest == hcpu_pkg::DEST_OUT)) begin
        dest = hcpu_pkg::DEST_NONE;
      end
    end
  end

  // bus source, a store from ram sees the floating bus
  always_comb begin
    case (bsel)
      hcpu_pkg::BUS_D: bus = state_i.dr;
      hcpu_pkg::BUS_RAM: bus = store ? noise_i : ram_data_i;
      hcpu_pkg::BUS_AC: bus = state_i.ac;
      default: bus = in_port_i;
    endcase
  end

  // alu
  always_comb begin
    case (ins)
      hcpu_pkg::INS_LD: alu = bus;
      hcpu_pkg::INS_AND: alu = state_i.ac & bus;
      hcpu_pkg::INS_OR: alu = state_i.ac | bus;
      hcpu_pkg::INS_XOR: alu = state_i.ac ^ bus;
      hcpu_pkg::INS_ADD: alu = state_i.ac + bus;
      hcpu_pkg::INS_SUB: alu = state_i.ac - bus;
      hcpu_pkg::INS_ST: alu = state_i.ac;
      default: alu = 8'h00 - state_i.ac;
    endcase
  end

  // branch condition and next pc
  always_comb begin
    if (state_i.ac == 8'h00) begin
      cond = hcpu_pkg::COND_EQ;
    end else if (state_i.ac[7]) begin
      cond = hcpu_pkg::COND_LT;
    end else begin
      cond = hcpu_pkg::COND_GT;
    end
    pc_inc = state_i.pc + 16'd1;
    pc_nxt = pc_inc;
    if (jump) begin
      if (mode == hcpu_pkg::MODE_D_AC) begin
        pc_nxt = {state_i.yr, bus};
      end else if (state_i.ir[3'd2 + 3'(cond)]) begin
        pc_nxt = {state_i.pc[15:8], bus};
      end
    end
  end

  // register writeback
  always_comb begin
    res_o.pc    = pc_nxt;
    res_o.ac    = (dest == hcpu_pkg::DEST_AC) ? alu : state_i.ac;
    res_o.y     = (dest == hcpu_pkg::DEST_Y) ? alu : state_i.yr;
    res_o.outr  = (dest == hcpu_pkg::DEST_OUT) ? alu : state_i.outr;
    if (incx) begin
      res_o.x = state_i.xr + 8'd1;
    end else if (dest == hcpu_pkg::DEST_X) begin
      res_o.x = alu;
    end else begin
      res_o.x = state_i.xr;
    end
    res_o.bus   = bus;
    res_o.alu   = alu;
    res_o.addr  = hcpu_pkg::mode_addr(state_i.ir, state_i.dr, state_i.xr, state_i.yr);
    res_o.store = store;
    res_o.jump  = jump;
  end

endmodule

FILE: sv/eight_bit_harvard_cpu_cycle.sv
// One machine cycle of an 8-bit Harvard cpu per input item.
// in_i carries the program word fetched at the previous fetch_address plus
// the input port byte and the floating bus byte; out_o returns one item per
// input item with the new pc (next fetch address), the registers, the bus
// and alu bytes, the data address and the store and branch flags.
// Latency: the result item is valid the cycle after the input item is taken.
// Throughput: one item per cycle. The data ram has a registered
// read, so the operand read for the next instruction is issued while the
// current one executes, using its opcode, operand and the fresh x and y; a
// store to the same entry in that cycle is forwarded.
// A result waiting in the output register does not block input as long as
// out_o.ready is high in the same cycle; with out_o.ready low and a result
// pending, in_i.ready drops and the machine holds all state.
// Reset clears pc, ir, d, ac, x, y and out to zero; the data ram is not
// cleared and holds unknown bytes until stored to.
module eight_bit_harvard_cpu_cycle #(
  parameter int RAM_ADDR_BITS = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcpu_in_if.sink           in_i,
  hcpu_out_if.source        out_o
);

  localparam int RamDepth = 1 << RAM_ADDR_BITS;

  hcpu_pkg::cpu_state_t     state_q;
  hcpu_pkg::cpu_state_t     state_d;
  hcpu_pkg::exec_res_t      ex;
  hcpu_pkg::exec_res_t      res_q;
  logic                     out_valid_q;
  logic                     in_acc;
  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] wr_idx;
  logic [RAM_ADDR_BITS-1:0] rd_idx;
  logic [15:0]              rd_addr;
  logic [7:0]               ram_rdata;
  logic [7:0]               op_data;
  logic                     fwd_q;
  logic [7:0]               fwd_data_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // execute the instruction held in ir/d
  hcpu_exec u_exec (
    .state_i    (state_q),
    .ram_data_i (op_data),
    .in_port_i  (in_i.in_port),
    .noise_i    (in_i.noise_byte),
    .res_o      (ex)
  );

  // operand prefetch address for the instruction just fetched
  assign rd_addr = hcpu_pkg::mode_addr(in_i.fetched_opcode, in_i.fetched_operand,
                                       ex.x, ex.y);
  assign rd_idx  = rd_addr[RAM_ADDR_BITS-1:0];
  assign wr_idx  = ex.addr[RAM_ADDR_BITS-1:0];
  assign ram_we  = in_acc && ex.store;

  hcpu_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx),
    .wdata_i (ex.bus),
    .re_i    (in_acc),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // store-to-prefetch forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= ram_we && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= ex.bus;
    end
  end

  assign op_data = fwd_q ? fwd_data_q : ram_rdata;

  // next architectural state
  always_comb begin
    state_d.pc   = ex.pc;
    state_d.ir   = in_i.fetched_opcode;
    state_d.dr   = in_i.fetched_operand;
    state_d.ac   = ex.ac;
    state_d.xr   = ex.x;
    state_d.yr   = ex.y;
    state_d.outr = ex.outr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= ex;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fetch_address = res_q.pc;
  assign out_o.out_port      = res_q.outr;
  assign out_o.accumulator   = res_q.ac;
  assign out_o.x_value       = res_q.x;
  assign out_o.y_value       = res_q.y;
  assign out_o.bus_value     = res_q.bus;
  assign out_o.alu_value     = res_q.alu;
  assign out_o.ram_address   = res_q.addr;
  assign out_o.ram_written   = res_q.store;
  assign out_o.jump_op       = res_q.jump;

  // checks
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_acc)
    else $error("item accepted while result stalled");

  a_fwd_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ram_we && (wr_idx == rd_idx)) |=> (fwd_q && fwd_data_q == $past(ex.bus)))
    else $error("store not forwarded to operand prefetch");

  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !ex.jump) |=> (state_q.pc == $past(state_q.pc) + 16'd1))
    else $error("pc did not advance on non-branch");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(state_q))
    else $error("state changed without an accepted item");

endmodule

FILE: verif/tb.sv
module tb;
  import hcpu_pkg::*;

  localparam int RAM_BITS      = 15;
  localparam int RAM_WORDS     = 1 << RAM_BITS;
  localparam int RANDOM_ITEMS  = 730;
  localparam int QUIET_FIRST   = 200;
  localparam int QUIET_LAST    = 350;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 29;

  // branch condition masks in the mode field
  localparam logic [2:0] BR_FAR = 3'b000;
  localparam logic [2:0] BR_GT  = 3'b001 << COND_GT;
  localparam logic [2:0] BR_LT  = 3'b001 << COND_LT;
  localparam logic [2:0] BR_EQ  = 3'b001 << COND_EQ;
  localparam logic [2:0] BR_ALL = BR_GT | BR_LT | BR_EQ;

  // cpu state mirror, expected cycle outcomes and result checking
  class cycle_scoreboard;
    cpu_state_t st;
    logic [7:0] mem [RAM_WORDS];
    bit         written [RAM_WORDS];
    int         written_list[$];
    exec_res_t  expected_cycles[$];
    int         errors;
    int         n_items;
    int         n_stores;
    int         n_ram_reads;
    int         n_branches;

    function new();
      st = '0;
      errors = 0;
      n_items = 0;
      n_stores = 0;
      n_ram_reads = 0;
      n_branches = 0;
    endfunction

    // data address for the instruction held in s; a branch uses {0, d}
    function logic [15:0] data_addr(cpu_state_t s);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = s.dr;
      hi = 8'h00;
      if (ins_e'(s.ir[7:5]) != INS_BR) begin
        case (mode_e'(s.ir[4:2]))
          MODE_X_AC: lo = s.xr;
          MODE_YD_AC: hi = s.yr;
          MODE_YX_AC, MODE_YXINC_OUT: begin
            lo = s.xr;
            hi = s.yr;
          end
          default: ;
        endcase
      end
      return {hi, lo};
    endfunction

    // one machine cycle on the current state, without committing it
    function exec_res_t exec_cycle(input logic [7:0] in_byte, input logic [7:0] noise,
                                   output cpu_state_t nxt);
      ins_e       ins;
      logic       store;
      logic       jump;
      dest_e      dest;
      logic       incx;
      logic [15:0] addr;
      logic [7:0] bus;
      logic [7:0] alu;
      logic [15:0] npc;
      logic [1:0] cond;
      exec_res_t  r;
      ins   = ins_e'(st.ir[7:5]);
      store = (ins == INS_ST);
      jump  = (ins == INS_BR);
      dest  = DEST_NONE;
      incx  = 1'b0;
      if (!jump) begin
        case (mode_e'(st.ir[4:2]))
          MODE_D_AC, MODE_X_AC, MODE_YD_AC, MODE_YX_AC: dest = DEST_AC;
          MODE_D_X: dest = DEST_X;
          MODE_D_Y: dest = DEST_Y;
          MODE_D_OUT: dest = DEST_OUT;
          default: begin
            dest = DEST_OUT;
            incx = 1'b1;
          end
        endcase
        // stores never load ac or out
        if (store && (dest == DEST_AC || dest == DEST_OUT)) dest = DEST_NONE;
      end
      addr = data_addr(st);

      // bus source; a store from ram sees the floating bus
      case (bus_e'(st.ir[1:0]))
        BUS_D: bus = st.dr;
        BUS_RAM: bus = store ? noise : mem[addr[RAM_BITS-1:0]];
        BUS_AC: bus = st.ac;
        default: bus = in_byte;
      endcase

      case (ins)
        INS_LD: alu = bus;
        INS_AND: alu = st.ac & bus;
        INS_OR: alu = st.ac | bus;
        INS_XOR: alu = st.ac ^ bus;
        INS_ADD: alu = st.ac + bus;
        INS_SUB: alu = st.ac - bus;
        INS_ST: alu = st.ac;
        default: alu = 8'h00 - st.ac;
      endcase

      nxt = st;
      case (dest)
        DEST_AC: nxt.ac = alu;
        DEST_X: nxt.xr = alu;
        DEST_Y: nxt.yr = alu;
        DEST_OUT: nxt.outr = alu;
        default: ;
      endcase
      if (incx) nxt.xr = st.xr + 8'd1;

      // next pc: far jump, conditional jump in page, or fall through
      npc = st.pc + 16'd1;
      if (jump) begin
        cond = (st.ac == 8'h00) ? COND_EQ : (st.ac[7] ? COND_LT : COND_GT);
        if (st.ir[4:2] == BR_FAR) npc = {st.yr, bus};
        else if ((st.ir[4:2] & (3'b001 << cond)) != 3'b000) npc = {st.pc[15:8], bus};
      end
      nxt.pc = npc;

      r.pc    = npc;
      r.ac    = nxt.ac;
      r.x     = nxt.xr;
      r.y     = nxt.yr;
      r.outr  = nxt.outr;
      r.bus   = bus;
      r.alu   = alu;
      r.addr  = addr;
      r.store = store;
      r.jump  = jump;
      return r;
    endfunction

    // true when the instruction in s reads no ram entry that is still unwritten
    function bit read_ok(cpu_state_t s, exec_res_t cur);
      int idx;
      if (bus_e'(s.ir[1:0]) != BUS_RAM || ins_e'(s.ir[7:5]) == INS_ST) return 1'b1;
      idx = int'(data_addr(s) & 16'(RAM_WORDS - 1));
      return written[idx] || (cur.store && idx == int'(cur.addr & 16'(RAM_WORDS - 1)));
    endfunction

    function logic [7:0] pick_operand();
      int sel;
      logic [7:0] v;
      sel = $urandom_range(0, 3);
      v = 8'($urandom_range(0, 255));
      if (sel == 2) begin
        case ($urandom_range(0, 3))
          0: v = 8'h00;
          1: v = 8'hff;
          2: v = 8'h7f;
          default: v = 8'h80;
        endcase
      end else if (sel == 3 && written_list.size() > 0) begin
        v = 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
      end
      return v;
    endfunction

    // accepted input item: execute, latch the new program word, queue the outcome
    function void note_input(logic [7:0] opc, logic [7:0] opd, logic [7:0] in_byte,
                             logic [7:0] noise);
      exec_res_t  r;
      cpu_state_t nxt;
      int         idx;
      r = exec_cycle(in_byte, noise, nxt);
      idx = int'(r.addr & 16'(RAM_WORDS - 1));
      if (r.store) begin
        mem[idx] = r.bus;
        if (!written[idx]) begin
          written[idx] = 1'b1;
          written_list.push_back(idx);
        end
        n_stores++;
      end else if (bus_e'(st.ir[1:0]) == BUS_RAM) begin
        n_ram_reads++;
      end
      if (r.jump) n_branches++;
      nxt.ir = opc;
      nxt.dr = opd;
      st = nxt;
      n_items++;
      expected_cycles.push_back(r);
    endfunction

    function string show(exec_res_t r);
      return $sformatf("pc=%h out=%h ac=%h x=%h y=%h bus=%h alu=%h addr=%h st=%b br=%b",
                       r.pc, r.outr, r.ac, r.x, r.y, r.bus, r.alu, r.addr, r.store, r.jump);
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t exp;
      string     bad;
      if (expected_cycles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %s", show(got));
        return;
      end
      exp = expected_cycles.pop_front();
      bad = "";
      if (got.pc !== exp.pc) bad = {bad, " fetch_address"};
      if (got.outr !== exp.outr) bad = {bad, " out_port"};
      if (got.ac !== exp.ac) bad = {bad, " accumulator"};
      if (got.x !== exp.x) bad = {bad, " x_value"};
      if (got.y !== exp.y) bad = {bad, " y_value"};
      if (got.bus !== exp.bus) bad = {bad, " bus_value"};
      if (got.alu !== exp.alu) bad = {bad, " alu_value"};
      if (got.addr !== exp.addr) bad = {bad, " ram_address"};
      if (got.store !== exp.store) bad = {bad, " ram_written"};
      if (got.jump !== exp.jump) bad = {bad, " jump_op"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch in%s", bad);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   hold_req;
  int   stall_cycles;
  cycle_scoreboard sb;

  hcpu_in_if  in_if ();
  hcpu_out_if out_if ();

  eight_bit_harvard_cpu_cycle #(
    .RAM_ADDR_BITS(RAM_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] enc(ins_e i, logic [2:0] m, bus_e b);
    return {i, m, b};
  endfunction

  function automatic logic [7:0] rb();
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one item from a falling edge and hold it until it is taken
  task automatic send(input logic [7:0] opc, input logic [7:0] opd,
                      input logic [7:0] in_byte, input logic [7:0] noise);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid           = 1'b1;
    in_if.fetched_opcode  = opc;
    in_if.fetched_operand = opd;
    in_if.in_port         = in_byte;
    in_if.noise_byte      = noise;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(opc, opd, in_byte, noise);
    @(negedge clk);
  endtask

  // random item whose next instruction never reads an unwritten ram entry
  task automatic send_random();
    logic [7:0] in_byte;
    logic [7:0] noise;
    logic [7:0] opc;
    logic [7:0] opd;
    exec_res_t  cur;
    cpu_state_t nxt;
    cpu_state_t s;
    int         tries;
    in_byte = rb();
    noise   = rb();
    cur = sb.exec_cycle(in_byte, noise, nxt);
    for (tries = 0; tries < 16; tries++) begin
      opc = rb();
      opd = sb.pick_operand();
      s = nxt;
      s.ir = opc;
      s.dr = opd;
      if (sb.read_ok(s, cur)) break;
    end
    if (tries == 16) opc[1:0] = BUS_D;
    send(opc, opd, in_byte, noise);
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // take each accepted result item
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result('{pc: out_if.fetch_address, ac: out_if.accumulator,
                        x: out_if.x_value, y: out_if.y_value, outr: out_if.out_port,
                        bus: out_if.bus_value, alu: out_if.alu_value,
                        addr: out_if.ram_address, store: out_if.ram_written,
                        jump: out_if.jump_op});
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout after %0d idle cycles", stall_cycles);
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int i;
    sb = new();
    stall_cycles          = 0;
    quiet                 = 1'b0;
    hold_req              = 1'b0;
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.fetched_opcode  = 8'h00;
    in_if.fetched_operand = 8'h00;
    in_if.in_port         = 8'h00;
    in_if.noise_byte      = 8'h00;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed program; in_port and noise of an item feed the word sent before it
    send(enc(INS_LD, MODE_D_AC, BUS_D), 8'hff, rb(), rb());
    send(enc(INS_ST, MODE_D_AC, BUS_AC), 8'h10, rb(), rb());
    send(enc(INS_ST, MODE_D_X, BUS_RAM), 8'h11, rb(), rb());
    // floating bus byte stored by the ram-sourced store
    send(enc(INS_LD, MODE_D_Y, BUS_D), 8'h80, 8'h00, 8'ha5);
    // y=80 so this store wraps around the top of the ram
    send(enc(INS_ST, MODE_YX_AC, BUS_D), 8'h3c, rb(), rb());
    send(enc(INS_LD, MODE_D_X, BUS_D), 8'h00, rb(), rb());
    send(enc(INS_AND, MODE_YD_AC, BUS_RAM), 8'hff, rb(), rb());
    send(enc(INS_OR, MODE_X_AC, BUS_IN), 8'h55, rb(), rb());
    send(enc(INS_XOR, MODE_D_AC, BUS_AC), 8'h00, 8'hff, rb());
    send(enc(INS_ADD, MODE_D_AC, BUS_D), 8'hff, rb(), rb());
    send(enc(INS_ADD, MODE_D_AC, BUS_D), 8'h01, rb(), rb());
    send(enc(INS_SUB, MODE_D_AC, BUS_D), 8'h01, rb(), rb());
    send(enc(INS_LD, MODE_YXINC_OUT, BUS_IN), 8'h00, rb(), rb());
    // store through the incrementing mode still bumps x
    send(enc(INS_ST, MODE_YXINC_OUT, BUS_AC), 8'h00, 8'h00, rb());
    send(enc(INS_LD, MODE_D_OUT, BUS_RAM), 8'h11, rb(), rb());
    send(enc(INS_BR, BR_FAR, BUS_D), 8'h40, rb(), rb());
    send(enc(INS_BR, BR_GT, BUS_D), 8'h00, rb(), rb());
    send(enc(INS_BR, BR_LT, BUS_D), 8'h20, rb(), rb());
    send(enc(INS_LD, MODE_D_AC, BUS_D), 8'h00, rb(), rb());
    send(enc(INS_BR, BR_EQ, BUS_RAM), 8'h10, rb(), rb());
    send(enc(INS_LD, MODE_D_Y, BUS_D), 8'hff, rb(), rb());
    // far jump to ffff, then the pc wraps to zero
    send(enc(INS_BR, BR_FAR, BUS_D), 8'hff, rb(), rb());
    send(enc(INS_LD, MODE_D_AC, BUS_D), 8'h01, rb(), rb());
    send(enc(INS_BR, BR_ALL, BUS_AC), 8'h00, rb(), rb());
    send(enc(INS_SUB, MODE_D_AC, BUS_AC), 8'h00, rb(), rb());
    send(enc(INS_BR, BR_ALL, BUS_IN), 8'hff, rb(), rb());

    // random program with a no-idle stretch and one long output hold-off
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
      if (i == HOLD_AT) hold_req = 1'b1;
      send_random();
    end
    quiet = 1'b0;
    in_if.valid = 1'b0;

    while (sb.expected_cycles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("summary: %0d cycles executed, %0d stores, %0d ram reads, %0d branches",
             sb.n_items, sb.n_stores, sb.n_ram_reads, sb.n_branches);
    $display("summary: %0d ram entries written, %0d mismatching items",
             sb.written_list.size(), sb.errors);
    if (sb.errors == 0 && sb.expected_cycles.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/hcpu_pkg.sv
sv/hcpu_in_if.sv
sv/hcpu_out_if.sv
sv/hcpu_ram.sv
sv/hcpu_exec.sv
sv/eight_bit_harvard_cpu_cycle.sv
verif/tb.sv
